// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/fsd_pkg.sv =====
// types, constants and tables of the fubini-study distance block
package fsd_pkg;
    localparam int AMP_W = 16;
    localparam int ACC_W = 50;
    localparam int ANG_W = 16;
    localparam int NUM_W = 101;
    localparam int HALF_W = 25;
    localparam int XY_W = 34;
    localparam int Z_W = 24;
    localparam int CNT_W = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int MUL_STEPS = 12;
    localparam int DIV_STEPS = 60;
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_STEPS = 20;

    typedef struct packed {
        logic signed [AMP_W-1:0] v_re;
        logic signed [AMP_W-1:0] v_im;
        logic signed [AMP_W-1:0] w_re;
        logic signed [AMP_W-1:0] w_im;
        logic                    final_pair;
    } in_item_t;

    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic             zero_norm;
    } out_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] dot_re;
        logic [ACC_W-1:0] dot_im;
        logic [ACC_W-1:0] v_norm;
        logic [ACC_W-1:0] w_norm;
    } sums_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_MUL, BK_CMP, BK_NORM, BK_DIV, BK_SQ1, BK_CSQ, BK_SQ2, BK_CORDIC,
        BK_DONE
    } back_state_t;

    function automatic logic [19:0] atan_q20(input logic [4:0] i);
        logic [19:0] r;
        case (i)
            5'd0:  r = 20'd823550;
            5'd1:  r = 20'd486170;
            5'd2:  r = 20'd256879;
            5'd3:  r = 20'd130396;
            5'd4:  r = 20'd65451;
            5'd5:  r = 20'd32757;
            5'd6:  r = 20'd16383;
            5'd7:  r = 20'd8192;
            5'd8:  r = 20'd4096;
            5'd9:  r = 20'd2048;
            5'd10: r = 20'd1024;
            5'd11: r = 20'd512;
            5'd12: r = 20'd256;
            5'd13: r = 20'd128;
            5'd14: r = 20'd64;
            5'd15: r = 20'd32;
            5'd16: r = 20'd16;
            5'd17: r = 20'd8;
            5'd18: r = 20'd4;
            5'd19: r = 20'd2;
            default: r = 20'd0;
        endcase
        return r;
    endfunction
endpackage

// ===== rtl/fsd_front.sv =====
// front end: item intake, products and running sums
module fsd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fsd_pkg::in_item_t s_item,
    output logic             push_valid,
    input  logic             push_ready,
    output fsd_pkg::sums_t   push_data
);
    logic                      p_valid_reg, p_valid_next;
    logic                      p_final_reg;
    logic signed [31:0]        rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [31:0]        vr2_reg, vi2_reg, wr2_reg, wi2_reg;
    logic [fsd_pkg::ACC_W-1:0] dr_reg, di_reg, vn_reg, wn_reg;
    logic signed [32:0]        dr_t, di_t, vn_t, wn_t;
    logic                      p_adv;
    fsd_pkg::sums_t            sums;

    assign p_adv   = !p_final_reg || push_ready;
    assign s_ready = !p_valid_reg || p_adv;
    assign p_valid_next = (s_valid && s_ready) ? 1'b1 : (p_adv ? 1'b0 : p_valid_reg);

    assign dr_t = 33'(rr_reg) + 33'(ii_reg);
    assign di_t = 33'(ri_reg) - 33'(ir_reg);
    assign vn_t = 33'(vr2_reg) + 33'(vi2_reg);
    assign wn_t = 33'(wr2_reg) + 33'(wi2_reg);

    always_comb begin
        sums.dot_re = dr_reg + fsd_pkg::ACC_W'(dr_t);
        sums.dot_im = di_reg + fsd_pkg::ACC_W'(di_t);
        sums.v_norm = vn_reg + fsd_pkg::ACC_W'(vn_t);
        sums.w_norm = wn_reg + fsd_pkg::ACC_W'(wn_t);
    end

    assign push_valid = p_valid_reg && p_final_reg;
    assign push_data  = sums;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            p_final_reg <= 1'b0;
            dr_reg      <= '0;
            di_reg      <= '0;
            vn_reg      <= '0;
            wn_reg      <= '0;
        end else begin
            p_valid_reg <= p_valid_next;
            if (s_valid && s_ready) begin
                p_final_reg <= s_item.final_pair;
            end
            if (p_valid_reg && p_adv) begin
                if (p_final_reg) begin
                    dr_reg <= '0;
                    di_reg <= '0;
                    vn_reg <= '0;
                    wn_reg <= '0;
                end else begin
                    dr_reg <= sums.dot_re;
                    di_reg <= sums.dot_im;
                    vn_reg <= sums.v_norm;
                    wn_reg <= sums.w_norm;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rr_reg  <= s_item.v_re * s_item.w_re;
            ii_reg  <= s_item.v_im * s_item.w_im;
            ri_reg  <= s_item.v_re * s_item.w_im;
            ir_reg  <= s_item.v_im * s_item.w_re;
            vr2_reg <= s_item.v_re * s_item.v_re;
            vi2_reg <= s_item.v_im * s_item.v_im;
            wr2_reg <= s_item.w_re * s_item.w_re;
            wi2_reg <= s_item.w_im * s_item.w_im;
        end
    end
endmodule

// ===== rtl/fsd_queue.sv =====
// short queue of finished sums between front and back
`include "assert_macros.svh"
module fsd_queue #(
    parameter int DEPTH = fsd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  fsd_pkg::sums_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fsd_pkg::sums_t pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsd_pkg::sums_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_AT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_push_counts, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_NEXT(a_pop_counts, aclk, aresetn, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)
endmodule

// ===== rtl/fsd_back.sv =====
// back end: ratio, square roots and cordic arccosine, one vector pair at a time
`include "assert_macros.svh"
module fsd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  fsd_pkg::sums_t     pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fsd_pkg::out_item_t m_item
);
    localparam int NW = fsd_pkg::NUM_W;
    localparam int AW = fsd_pkg::ACC_W;
    localparam int HW = fsd_pkg::HALF_W;
    localparam int CW = fsd_pkg::CNT_W;

    fsd_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]        re_reg, re_next, im_reg, im_next, nv_reg, nv_next, nw_reg, nw_next;
    logic [NW-1:0]        num_reg, num_next, den_reg, den_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [63:0]          rem_reg, rem_next, res_reg, res_next;
    logic [30:0]          c_reg, c_next;
    logic signed [fsd_pkg::XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [fsd_pkg::Z_W-1:0]  z_reg, z_next;
    logic                 zero_reg, zero_next;
    logic                 m_valid_reg, m_valid_next;
    fsd_pkg::out_item_t   m_item_reg, m_item_next;

    logic [AW-1:0]        a_op, b_op;
    logic [HW-1:0]        a_half, b_half;
    logic [2*HW-1:0]      pp;
    logic [NW-1:0]        pp_sh;
    logic [64:0]          rem2;
    logic [63:0]          sq_bit, sq_try;
    logic                 sq_take;
    logic signed [fsd_pkg::XY_W-1:0] dx, dy;
    logic signed [fsd_pkg::Z_W-1:0]  at, zr;
    logic                 step_last, out_free, den_big;
    logic [fsd_pkg::ANG_W-1:0] ang;

    assign out_free  = !m_valid_reg || m_ready;
    assign den_big   = |den_reg[NW-1:62];
    assign pop_ready = (state_reg == fsd_pkg::BK_IDLE);

    // shared 25x25 partial product
    always_comb begin
        case (cnt_reg[3:2])
            2'd0: begin
                a_op = re_reg;
                b_op = re_reg;
            end
            2'd1: begin
                a_op = im_reg;
                b_op = im_reg;
            end
            default: begin
                a_op = nv_reg;
                b_op = nw_reg;
            end
        endcase
        a_half = cnt_reg[1] ? a_op[AW-1:HW] : a_op[HW-1:0];
        b_half = cnt_reg[0] ? b_op[AW-1:HW] : b_op[HW-1:0];
        pp     = a_half * b_half;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = NW'(pp);
            2'd1:    pp_sh = NW'(pp) << HW;
            default: pp_sh = NW'(pp) << (2 * HW);
        endcase
    end

    assign rem2    = {rem_reg, 1'b0};
    assign sq_bit  = 64'h4000_0000_0000_0000 >> {cnt_reg[4:0], 1'b0};
    assign sq_try  = res_reg + sq_bit;
    assign sq_take = (rem_reg >= sq_try);
    assign dx      = y_reg >>> cnt_reg[4:0];
    assign dy      = x_reg >>> cnt_reg[4:0];
    assign at      = fsd_pkg::Z_W'(fsd_pkg::atan_q20(cnt_reg[4:0]));
    assign zr      = z_reg + fsd_pkg::Z_W'(32);
    assign ang     = (z_reg <= 0) ? '0 : zr[21:6];

    always_comb begin
        case (state_reg)
            fsd_pkg::BK_MUL:    step_last = (cnt_reg == CW'(fsd_pkg::MUL_STEPS - 1));
            fsd_pkg::BK_DIV:    step_last = (cnt_reg == CW'(fsd_pkg::DIV_STEPS - 1));
            fsd_pkg::BK_CORDIC: step_last = (cnt_reg == CW'(fsd_pkg::CORDIC_STEPS - 1));
            default:            step_last = (cnt_reg == CW'(fsd_pkg::SQRT_STEPS - 1));
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsd_pkg::BK_IDLE: begin
                if (pop_valid) begin
                    if (pop_data.v_norm == '0 || pop_data.w_norm == '0) begin
                        state_next = fsd_pkg::BK_DONE;
                    end else begin
                        state_next = fsd_pkg::BK_MUL;
                    end
                end
            end
            fsd_pkg::BK_MUL: begin
                if (step_last) state_next = fsd_pkg::BK_CMP;
            end
            fsd_pkg::BK_CMP: begin
                state_next = (num_reg >= den_reg) ? fsd_pkg::BK_SQ1 : fsd_pkg::BK_NORM;
            end
            fsd_pkg::BK_NORM: begin
                if (!den_big) state_next = fsd_pkg::BK_DIV;
            end
            fsd_pkg::BK_DIV: begin
                if (step_last) state_next = fsd_pkg::BK_SQ1;
            end
            fsd_pkg::BK_SQ1: begin
                if (step_last) state_next = fsd_pkg::BK_CSQ;
            end
            fsd_pkg::BK_CSQ: begin
                state_next = fsd_pkg::BK_SQ2;
            end
            fsd_pkg::BK_SQ2: begin
                if (step_last) state_next = fsd_pkg::BK_CORDIC;
            end
            fsd_pkg::BK_CORDIC: begin
                if (step_last) state_next = fsd_pkg::BK_DONE;
            end
            fsd_pkg::BK_DONE: begin
                if (out_free) state_next = fsd_pkg::BK_IDLE;
            end
            default: state_next = fsd_pkg::BK_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        re_next      = re_reg;
        im_next      = im_reg;
        nv_next      = nv_reg;
        nw_next      = nw_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        cnt_next     = cnt_reg + 1'b1;
        rem_next     = rem_reg;
        res_next     = res_reg;
        c_next       = c_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        zero_next    = zero_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_item_next  = m_item_reg;
        case (state_reg)
            fsd_pkg::BK_IDLE: begin
                cnt_next  = '0;
                re_next   = pop_data.dot_re[AW-1] ? (~pop_data.dot_re + 1'b1) : pop_data.dot_re;
                im_next   = pop_data.dot_im[AW-1] ? (~pop_data.dot_im + 1'b1) : pop_data.dot_im;
                nv_next   = pop_data.v_norm;
                nw_next   = pop_data.w_norm;
                num_next  = '0;
                den_next  = '0;
                z_next    = '0;
                zero_next = (pop_data.v_norm == '0 || pop_data.w_norm == '0);
            end
            fsd_pkg::BK_MUL: begin
                if (cnt_reg[3:2] == 2'd2) begin
                    den_next = den_reg + pp_sh;
                end else begin
                    num_next = num_reg + pp_sh;
                end
            end
            fsd_pkg::BK_CMP: begin
                cnt_next = '0;
                res_next = '0;
                rem_next = 64'h1000_0000_0000_0000;
            end
            fsd_pkg::BK_NORM: begin
                cnt_next = '0;
                if (den_big) begin
                    den_next = den_reg >> 1;
                    num_next = num_reg >> 1;
                end else begin
                    rem_next = num_reg[63:0];
                    res_next = '0;
                end
            end
            fsd_pkg::BK_DIV: begin
                if (rem2 >= {1'b0, den_reg[63:0]}) begin
                    rem_next = 64'(rem2 - {1'b0, den_reg[63:0]});
                    res_next = {res_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem2[63:0];
                    res_next = {res_reg[62:0], 1'b0};
                end
                if (step_last) begin
                    cnt_next = '0;
                    rem_next = {res_reg[62:0], rem2 >= {1'b0, den_reg[63:0]}};
                    res_next = '0;
                end
            end
            fsd_pkg::BK_SQ1, fsd_pkg::BK_SQ2: begin
                if (sq_take) begin
                    rem_next = rem_reg - sq_try;
                    res_next = (res_reg >> 1) + sq_bit;
                end else begin
                    res_next = res_reg >> 1;
                end
                if (step_last) begin
                    cnt_next = '0;
                    if (state_reg == fsd_pkg::BK_SQ1) begin
                        c_next = sq_take ? 31'((res_reg >> 1) + sq_bit) : 31'(res_reg >> 1);
                    end else begin
                        x_next = fsd_pkg::XY_W'(c_reg);
                        y_next = sq_take ? fsd_pkg::XY_W'((res_reg >> 1) + sq_bit)
                                         : fsd_pkg::XY_W'(res_reg >> 1);
                    end
                end
            end
            fsd_pkg::BK_CSQ: begin
                cnt_next = '0;
                res_next = '0;
                rem_next = 64'h1000_0000_0000_0000 - 64'(c_reg * c_reg);
            end
            fsd_pkg::BK_CORDIC: begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
            end
            fsd_pkg::BK_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_item_next.angle     = ang;
                    m_item_next.zero_norm = zero_reg;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fsd_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        re_reg     <= re_next;
        im_reg     <= im_next;
        nv_reg     <= nv_next;
        nw_reg     <= nw_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        c_reg      <= c_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        zero_reg   <= zero_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_AT(a_zero_angle, aclk, aresetn, !(m_valid_reg && m_item_reg.zero_norm) || m_item_reg.angle == '0)
    `ASSERT_AT(a_angle_bound, aclk, aresetn, !m_valid_reg || m_item_reg.angle <= 16'd25800)
    `ASSERT_AT(a_div_norm, aclk, aresetn, state_reg != fsd_pkg::BK_DIV || !den_big)
endmodule

// ===== rtl/fubini_study_distance.sv =====
// top level of the fubini-study distance block
// s_item carries one pair of q1.15 complex amplitudes of v and w; final_pair
// marks the last pair of the two vectors. no result comes for other items.
// m_item gives the angle between the vectors in unsigned q2.14 radians, or
// zero_norm with angle 0 when either vector has zero norm.
// the front end takes one item per cycle unless a final item waits for
// queue room: products are registered, then added into four 50-bit sums;
// a final item hands its sums to a two-entry queue and clears them for the
// next vector pair. the back end works one queued pair at a time: 25x25
// partial products, up to 38 normalizing shifts, a restoring divide, two
// square roots with a squaring step, 20 cordic steps and an output state.
// when the ratio reaches 1 the shifts and the divide are skipped, and a
// zero norm goes straight to the output state.
// a stalled m_ready holds the result register and the back end; the queue
// then fills, and the front holds the next final item and takes no further
// item until the queue has room again.
// reset (aresetn low, synchronous) clears the sums, the queue and m_valid.
module fubini_study_distance #(
    parameter int QUEUE_DEPTH = fsd_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fsd_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output fsd_pkg::out_item_t m_item
);
    logic           push_valid, push_ready, pop_valid, pop_ready;
    fsd_pkg::sums_t push_data, pop_data;

    fsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    fsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );
endmodule
